/* hw/rtl/mpsm_pkg.sv */
// Shared types and constants of the multi-pattern string matcher.
// No dependencies.
`default_nettype none
package mpsm_pkg;

  localparam int NODE_COUNT      = 1024;
  localparam int ALPHABET_SIZE   = 256;
  localparam int MAX_PATTERNS    = 256;
  localparam int MAX_PATTERN_LEN = 32;
  localparam int MAX_RESULTS     = 32;

  localparam logic [1:0] REQ_PCHAR = 2'd0;
  localparam logic [1:0] REQ_PEND  = 2'd1;
  localparam logic [1:0] REQ_TEXT  = 2'd2;

  localparam logic [1:0] ST_MATCH     = 2'd0;
  localparam logic [1:0] ST_NODE_FULL = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [1:0] ST_TOO_MANY  = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  pattern_index;
    logic [31:0] start_position;
    logic        last_result;
  } res_t;

endpackage
`default_nettype wire

/* hw/rtl/mpsm_if.sv */
// Valid/ready channel interfaces for request and result transfers.
// No dependencies.
`default_nettype none
interface mpsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] symbol;
  logic       text_start;
  modport source(output valid, req_type, symbol, text_start, input ready);
  modport sink(input valid, req_type, symbol, text_start, output ready);
endinterface

interface mpsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  pattern_index;
  logic [31:0] start_position;
  logic        last_result;
  modport source(output valid, status, pattern_index, start_position, last_result,
                 input ready);
  modport sink(input valid, status, pattern_index, start_position, last_result,
               output ready);
endinterface
`default_nettype wire

/* hw/rtl/mpsm_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/mpsm_ctrl.sv */
// Matcher engine: sequencer around trie, goto, link, node, length and queue RAMs.
// Depends on mpsm_pkg and mpsm_ram.
`default_nettype none
module mpsm_ctrl #(
  parameter int NODE_COUNT      = mpsm_pkg::NODE_COUNT,
  parameter int ALPHABET_SIZE   = mpsm_pkg::ALPHABET_SIZE,
  parameter int MAX_PATTERNS    = mpsm_pkg::MAX_PATTERNS,
  parameter int MAX_PATTERN_LEN = mpsm_pkg::MAX_PATTERN_LEN
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     req_type,
  input  wire logic [7:0]     symbol,
  input  wire logic           text_start,
  output logic                res_valid,
  input  wire logic           res_ready,
  output mpsm_pkg::res_t      res
);
  localparam int NW     = $clog2(NODE_COUNT);
  localparam int AW     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int CDEPTH = NODE_COUNT << AW;
  localparam int CAW    = NW + AW;
  localparam int PW     = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int PCW    = $clog2(MAX_PATTERNS + 1);
  localparam int LW     = $clog2(MAX_PATTERN_LEN + 1);
  localparam int CW     = $clog2(NODE_COUNT + 1);
  localparam int RW     = $clog2(mpsm_pkg::MAX_RESULTS);

  typedef logic [AW-1:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod();
    mod_tab_t t;
    int r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      t[i] = AW'(r);
      r = (r + 1 == ALPHABET_SIZE) ? 0 : r + 1;
    end
    return t;
  endfunction

  localparam mod_tab_t SYM_MOD = build_mod();

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_PCH, S_TX, S_TX_G, S_TX_N, S_M_RD, S_M_LEN, S_EMIT,
    S_RB_INIT, S_RB_POP, S_RB_V, S_RB_SV, S_RB_RD, S_RB_CH, S_RB_LNK
  } state_t;

  state_t          state;
  logic [CAW-1:0]  clr;
  logic [AW-1:0]   sym;
  logic            restart;
  logic [CW-1:0]   node_count;
  logic [PCW-1:0]  pattern_count;
  logic [NW-1:0]   insert_cursor;
  logic [LW-1:0]   insert_depth;
  logic [NW-1:0]   scan_node;
  logic [31:0]     text_position;
  logic [31:0]     pos;
  logic            links_valid;
  logic [NW-1:0]   v;
  logic [NW-1:0]   vnext;
  logic [PW-1:0]   pat;
  logic [RW-1:0]   nres;
  logic            more;
  logic [NW-1:0]   sv;
  logic [NW-1:0]   u;
  logic [NW-1:0]   s;
  logic [AW-1:0]   c;
  logic [NW:0]     head;
  logic [NW:0]     tail;

  // RAM ports
  logic            ch_we, gt_we, lk_we, nd_we, pl_we, qu_we;
  logic [CAW-1:0]  ch_waddr, ch_raddr, gt_waddr, gt_raddr;
  logic [NW-1:0]   ch_wdata, ch_rdata, gt_wdata, gt_rdata;
  logic [NW-1:0]   lk_waddr, nl_raddr, qu_waddr, qu_raddr, qu_wdata, qu_rdata;
  logic [2*NW-1:0] lk_wdata, lk_rdata;
  logic [NW-1:0]   nd_waddr;
  logic [PW:0]     nd_wdata, nd_rdata;
  logic [PW-1:0]   pl_waddr, pl_raddr;
  logic [LW-1:0]   pl_wdata, pl_rdata;

  logic [NW-1:0]   lk_suf, lk_out;
  logic            nd_term;
  logic [PW-1:0]   nd_pat;
  logic [AW-1:0]   in_sym;
  logic [NW-1:0]   scan_eff, gsel, slink;
  logic [32:0]     endp, len_ext;
  logic            c_last;

  assign lk_suf  = lk_rdata[2*NW-1:NW];
  assign lk_out  = lk_rdata[NW-1:0];
  assign nd_term = nd_rdata[PW];
  assign nd_pat  = nd_rdata[PW-1:0];
  assign in_sym  = SYM_MOD[symbol];
  assign scan_eff = restart ? '0 : scan_node;
  assign gsel    = (v == '0) ? '0 : gt_rdata;
  assign slink   = (s != '0 && nd_term) ? s : lk_out;
  assign endp    = {1'b0, pos} + 33'd1;
  assign len_ext = 33'(pl_rdata);
  assign c_last  = (c == AW'(ALPHABET_SIZE - 1));
  assign in_ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  always_comb begin
    ch_we = 1'b0; ch_waddr = {insert_cursor, sym}; ch_wdata = node_count[NW-1:0];
    ch_raddr = {insert_cursor, in_sym};
    gt_we = 1'b0; gt_waddr = {v, c}; gt_wdata = gsel; gt_raddr = {sv, c};
    lk_we = 1'b0; lk_waddr = u; lk_wdata = {s, slink};
    nl_raddr = v;
    nd_we = 1'b0; nd_waddr = insert_cursor; nd_wdata = {1'b1, PW'(pattern_count)};
    pl_we = 1'b0; pl_waddr = PW'(pattern_count); pl_wdata = insert_depth;
    pl_raddr = nd_pat;
    qu_we = 1'b0; qu_waddr = tail[NW-1:0]; qu_wdata = ch_rdata; qu_raddr = head[NW-1:0];
    case (state)
      S_CLR: begin
        ch_we = 1'b1; ch_waddr = clr; ch_wdata = '0;
      end
      S_IDLE: begin
        if (in_valid && req_type == mpsm_pkg::REQ_PEND &&
            pattern_count < PCW'(MAX_PATTERNS)) begin
          nd_we = 1'b1;
          pl_we = 1'b1;
        end
      end
      S_PCH: begin
        if (ch_rdata == '0 && node_count < CW'(NODE_COUNT)) begin
          ch_we = 1'b1;
          nd_we = 1'b1; nd_waddr = node_count[NW-1:0]; nd_wdata = '0;
        end
      end
      S_TX:     gt_raddr = {scan_eff, sym};
      S_TX_G:   nl_raddr = gt_rdata;
      S_TX_N:   nl_raddr = (scan_node != '0 && nd_term) ? scan_node : lk_out;
      S_EMIT:   nl_raddr = vnext;
      S_RB_INIT: begin
        lk_we = 1'b1; lk_waddr = '0; lk_wdata = '0;
        qu_we = 1'b1; qu_waddr = '0; qu_wdata = '0;
      end
      S_RB_V:   nl_raddr = qu_rdata;
      S_RB_SV:  gt_raddr = {lk_suf, c};
      S_RB_RD:  ch_raddr = {v, c};
      S_RB_CH: begin
        gt_we = 1'b1;
        nl_raddr = gsel;
        if (ch_rdata != '0) begin
          gt_wdata = ch_rdata;
          qu_we = 1'b1;
        end
      end
      S_RB_LNK: lk_we = 1'b1;
      default: ;
    endcase
    if (state == S_RB_SV) ch_raddr = {v, c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr <= '0;
      node_count <= CW'(1);
      pattern_count <= '0;
      insert_cursor <= '0;
      insert_depth <= '0;
      scan_node <= '0;
      text_position <= '0;
      links_valid <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr <= clr + CAW'(1);
          if (clr == CAW'(CDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            sym <= in_sym;
            restart <= text_start;
            res.pattern_index <= '0;
            res.start_position <= '0;
            res.last_result <= 1'b1;
            more <= 1'b0;
            case (req_type)
              mpsm_pkg::REQ_PCHAR: begin
                if (insert_depth >= LW'(MAX_PATTERN_LEN)) begin
                  res.status <= mpsm_pkg::ST_TOO_LONG;
                  state <= S_EMIT;
                end else begin
                  state <= S_PCH;
                end
              end
              mpsm_pkg::REQ_PEND: begin
                insert_cursor <= '0;
                insert_depth <= '0;
                if (pattern_count >= PCW'(MAX_PATTERNS)) begin
                  res.status <= mpsm_pkg::ST_TOO_MANY;
                  state <= S_EMIT;
                end else begin
                  pattern_count <= pattern_count + PCW'(1);
                  links_valid <= 1'b0;
                end
              end
              mpsm_pkg::REQ_TEXT: begin
                state <= links_valid ? S_TX : S_RB_INIT;
              end
              default: ;
            endcase
          end
        end
        S_PCH: begin
          if (ch_rdata == '0) begin
            if (node_count >= CW'(NODE_COUNT)) begin
              res.status <= mpsm_pkg::ST_NODE_FULL;
              state <= S_EMIT;
            end else begin
              insert_cursor <= node_count[NW-1:0];
              insert_depth <= insert_depth + LW'(1);
              node_count <= node_count + CW'(1);
              links_valid <= 1'b0;
              state <= S_IDLE;
            end
          end else begin
            insert_cursor <= ch_rdata;
            insert_depth <= insert_depth + LW'(1);
            state <= S_IDLE;
          end
        end
        S_TX: begin
          pos <= restart ? '0 : text_position;
          if (restart) begin
            text_position <= 32'd1;
          end else if (text_position != '1) begin
            text_position <= text_position + 32'd1;
          end
          state <= S_TX_G;
        end
        S_TX_G: begin
          scan_node <= gt_rdata;
          state <= S_TX_N;
        end
        S_TX_N: begin
          nres <= '0;
          v <= (scan_node != '0 && nd_term) ? scan_node : lk_out;
          state <= ((scan_node != '0 && nd_term) || lk_out != '0) ? S_M_RD : S_IDLE;
        end
        S_M_RD: begin
          pat <= nd_pat;
          vnext <= lk_out;
          state <= S_M_LEN;
        end
        S_M_LEN: begin
          res.status <= mpsm_pkg::ST_MATCH;
          res.pattern_index <= 8'(pat);
          res.start_position <= (endp >= len_ext) ? 32'(endp - len_ext) : '0;
          res.last_result <= (vnext == '0) || (nres == RW'(mpsm_pkg::MAX_RESULTS - 1));
          more <= (vnext != '0) && (nres != RW'(mpsm_pkg::MAX_RESULTS - 1));
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            if (more) begin
              v <= vnext;
              nres <= nres + RW'(1);
              state <= S_M_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RB_INIT: begin
          head <= '0;
          tail <= (NW + 1)'(1);
          state <= S_RB_POP;
        end
        S_RB_POP: begin
          if (head == tail) begin
            links_valid <= 1'b1;
            state <= S_TX;
          end else begin
            state <= S_RB_V;
          end
        end
        S_RB_V: begin
          v <= qu_rdata;
          head <= head + (NW + 1)'(1);
          state <= S_RB_SV;
        end
        S_RB_SV: begin
          sv <= lk_suf;
          c <= '0;
          state <= S_RB_RD;
        end
        S_RB_RD: state <= S_RB_CH;
        S_RB_CH: begin
          if (ch_rdata != '0) begin
            u <= ch_rdata;
            s <= gsel;
            tail <= tail + (NW + 1)'(1);
            state <= S_RB_LNK;
          end else if (c_last) begin
            state <= S_RB_POP;
          end else begin
            c <= c + AW'(1);
            state <= S_RB_RD;
          end
        end
        S_RB_LNK: begin
          if (c_last) begin
            state <= S_RB_POP;
          end else begin
            c <= c + AW'(1);
            state <= S_RB_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mpsm_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata), .raddr(ch_raddr),
    .rdata(ch_rdata));
  mpsm_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_goto (
    .clk, .we(gt_we), .waddr(gt_waddr), .wdata(gt_wdata), .raddr(gt_raddr),
    .rdata(gt_rdata));
  mpsm_ram #(.WIDTH(2 * NW), .DEPTH(NODE_COUNT)) u_link (
    .clk, .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata), .raddr(nl_raddr),
    .rdata(lk_rdata));
  mpsm_ram #(.WIDTH(PW + 1), .DEPTH(NODE_COUNT)) u_node (
    .clk, .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata), .raddr(nl_raddr),
    .rdata(nd_rdata));
  mpsm_ram #(.WIDTH(LW), .DEPTH(MAX_PATTERNS)) u_plen (
    .clk, .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata), .raddr(pl_raddr),
    .rdata(pl_rdata));
  mpsm_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_queue (
    .clk, .we(qu_we), .waddr(qu_waddr), .wdata(qu_wdata), .raddr(qu_raddr),
    .rdata(qu_rdata));
endmodule
`default_nettype wire

/* hw/rtl/multi_pattern_string_matcher.sv */
// Top level of the multi-pattern matcher: engine plus result output register.
// Depends on mpsm_pkg, mpsm_if, mpsm_ctrl.
//
//  channel  dir  fields
//  in_ch    in   req_type, symbol, text_start
//  out_ch   out  status, pattern_index, start_position, last_result
//
// The first text character after a trie change triggers a link rebuild, which
// sweeps the goto/child RAMs over every symbol of each node.
// After rst, a clearing pass runs over the NODE_COUNT * 2**clog2(ALPHABET_SIZE)
// child RAM entries (262144 by default); no input transfer is taken meanwhile.
// A full output register whose result is not taken stalls the engine when it has the next result ready.
`default_nettype none
module multi_pattern_string_matcher #(
  parameter int NODE_COUNT      = mpsm_pkg::NODE_COUNT,
  parameter int ALPHABET_SIZE   = mpsm_pkg::ALPHABET_SIZE,
  parameter int MAX_PATTERNS    = mpsm_pkg::MAX_PATTERNS,
  parameter int MAX_PATTERN_LEN = mpsm_pkg::MAX_PATTERN_LEN
) (
  input wire logic clk,
  input wire logic rst,
  mpsm_in_if.sink    in_ch,
  mpsm_out_if.source out_ch
);
  logic           res_valid;
  logic           res_ready;
  mpsm_pkg::res_t res;
  logic           in_ready;
  logic           out_valid;
  mpsm_pkg::res_t out_res;

  mpsm_ctrl #(
    .NODE_COUNT(NODE_COUNT), .ALPHABET_SIZE(ALPHABET_SIZE),
    .MAX_PATTERNS(MAX_PATTERNS), .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ready),
    .req_type(in_ch.req_type), .symbol(in_ch.symbol), .text_start(in_ch.text_start),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign in_ch.ready = in_ready;
  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_res <= res;
      end
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_res.status;
  assign out_ch.pattern_index  = out_res.pattern_index;
  assign out_ch.start_position = out_res.start_position;
  assign out_ch.last_result    = out_res.last_result;

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.status == mpsm_pkg::ST_MATCH || out_res.last_result))
    else $error("status result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status != mpsm_pkg::ST_MATCH) |->
      (out_res.pattern_index == 8'd0 && out_res.start_position == 32'd0))
    else $error("status result carries payload");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid)
    else $error("pending result dropped");
endmodule
`default_nettype wire

/* tb/multi_pattern_string_matcher_test.sv */
// Self-checking testbench of multi_pattern_string_matcher: builds tries, scans text and
// checks every result transfer against an Aho-Corasick predictor kept in the bench.
// Depends on mpsm_pkg, mpsm_if and the matcher RTL.
`timescale 1ns / 100ps
module multi_pattern_string_matcher_test;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [1:0]     req;
    logic [7:0]     sym;
    logic           restart;
    int             reps;
    bit             typed;
    mpsm_pkg::res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mpsm_in_if  req_ch();
  mpsm_out_if res_ch();

  multi_pattern_string_matcher uut (
    .clk(clk),
    .rst(rst),
    .in_ch(req_ch),
    .out_ch(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // matcher state as predicted
  int   trie_child[mpsm_pkg::NODE_COUNT][mpsm_pkg::ALPHABET_SIZE];
  int   trie_goto[mpsm_pkg::NODE_COUNT][mpsm_pkg::ALPHABET_SIZE];
  int   fail_link[mpsm_pkg::NODE_COUNT];
  int   out_link[mpsm_pkg::NODE_COUNT];
  bit   is_term[mpsm_pkg::NODE_COUNT];
  int   term_pat[mpsm_pkg::NODE_COUNT];
  int   pat_len[mpsm_pkg::MAX_PATTERNS];
  int   bfs_q[mpsm_pkg::NODE_COUNT];
  int   n_nodes = 1;
  int   n_pats = 0;
  int   ins_node = 0;
  int   ins_depth = 0;
  int   scan_at = 0;
  int   text_pos = 0;
  bit   links_ok = 1'b0;

  mpsm_pkg::res_t expected_q[$];
  int   errors = 0;
  int   cycles = 0;
  bit   idle_on = 1'b1;
  int   stall_left = 0;

  function automatic mpsm_pkg::res_t mk_res(logic [1:0] st, int idx, longint start,
                                            bit last);
    mpsm_pkg::res_t r;
    r.status = st;
    r.pattern_index = idx[7:0];
    r.start_position = start[31:0];
    r.last_result = last;
    return r;
  endfunction

  function automatic void queue_res(ref mpsm_pkg::res_t q[$], input mpsm_pkg::res_t r);
    q = {q, r};
  endfunction

  function automatic void rebuild_links();
    int head;
    int tail;
    int v;
    int sv;
    int u;
    int s;
    head = 0;
    tail = 0;
    fail_link[0] = 0;
    out_link[0] = 0;
    bfs_q[tail++] = 0;
    while (head < tail) begin
      v = bfs_q[head++];
      sv = fail_link[v];
      for (int c = 0; c < mpsm_pkg::ALPHABET_SIZE; c++) begin
        u = trie_child[v][c];
        if (u != 0) begin
          s = (v == 0) ? 0 : trie_goto[sv][c];
          fail_link[u] = s;
          out_link[u] = (s != 0 && is_term[s]) ? s : out_link[s];
          trie_goto[v][c] = u;
          if (tail < mpsm_pkg::NODE_COUNT) bfs_q[tail++] = u;
        end else begin
          trie_goto[v][c] = (v == 0) ? 0 : trie_goto[sv][c];
        end
      end
    end
    links_ok = 1'b1;
  endfunction

  // returns the results the item causes, in order
  function automatic void predict_results(logic [1:0] req, logic [7:0] sym_in,
                                          logic restart, ref mpsm_pkg::res_t got[$]);
    int sym;
    int nxt;
    int v;
    int p;
    longint pos;
    longint endp;
    got.delete();
    sym = sym_in % mpsm_pkg::ALPHABET_SIZE;
    case (req)
      mpsm_pkg::REQ_PCHAR: begin
        if (ins_depth >= mpsm_pkg::MAX_PATTERN_LEN) begin
          queue_res(got, mk_res(mpsm_pkg::ST_TOO_LONG, 0, 0, 1));
          return;
        end
        nxt = trie_child[ins_node][sym];
        if (nxt == 0) begin
          if (n_nodes >= mpsm_pkg::NODE_COUNT) begin
            queue_res(got, mk_res(mpsm_pkg::ST_NODE_FULL, 0, 0, 1));
            return;
          end
          nxt = n_nodes++;
          trie_child[ins_node][sym] = nxt;
          links_ok = 1'b0;
        end
        ins_node = nxt;
        ins_depth++;
      end
      mpsm_pkg::REQ_PEND: begin
        if (n_pats >= mpsm_pkg::MAX_PATTERNS) begin
          queue_res(got, mk_res(mpsm_pkg::ST_TOO_MANY, 0, 0, 1));
        end else begin
          is_term[ins_node] = 1'b1;
          term_pat[ins_node] = n_pats;
          pat_len[n_pats] = ins_depth;
          n_pats++;
          links_ok = 1'b0;
        end
        ins_node = 0;
        ins_depth = 0;
      end
      mpsm_pkg::REQ_TEXT: begin
        if (!links_ok) rebuild_links();
        if (restart) begin
          scan_at = 0;
          text_pos = 0;
        end
        pos = longint'(unsigned'(text_pos));
        if (text_pos != -1) text_pos++;
        scan_at = trie_goto[scan_at][sym];
        v = scan_at;
        if (!(v != 0 && is_term[v])) v = out_link[v];
        while (v != 0 && got.size() < mpsm_pkg::MAX_RESULTS) begin
          p = term_pat[v] % mpsm_pkg::MAX_PATTERNS;
          endp = pos + 1;
          queue_res(got, mk_res(mpsm_pkg::ST_MATCH, p,
                                (endp >= pat_len[p]) ? endp - pat_len[p] : 0, 0));
          v = out_link[v];
        end
        if (got.size() > 0) got[got.size() - 1].last_result = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send(logic [1:0] req, logic [7:0] sym, logic restart,
                      bit typed = 0, mpsm_pkg::res_t typed_res = '0);
    mpsm_pkg::res_t got[$];
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= req;
    req_ch.symbol <= sym;
    req_ch.text_start <= restart;
    do @(posedge clk); while (!req_ch.ready);
    predict_results(req, sym, restart, got);
    if (typed) queue_res(expected_q, typed_res);
    else foreach (got[i]) queue_res(expected_q, got[i]);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_sym();
    return ($urandom_range(0, 7) != 0) ? 8'(8'h61 + $urandom_range(0, 2))
                                       : 8'($urandom_range(0, 255));
  endfunction

  // result side: random stall bursts, compare at rising edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 14);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mpsm_pkg::res_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_pattern_string_matcher regression: fail");
      $finish;
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: status %0d", res_ch.status);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          errors++;
        end
        if (res_ch.pattern_index !== want.pattern_index) begin
          $error("pattern_index: expected %0d, got %0d", want.pattern_index,
                 res_ch.pattern_index);
          errors++;
        end
        if (res_ch.start_position !== want.start_position) begin
          $error("start_position: expected %0d, got %0d", want.start_position,
                 res_ch.start_position);
          errors++;
        end
        if (res_ch.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result,
                 res_ch.last_result);
          errors++;
        end
      end
    end
  end

  stim_row_t directed[$] = '{
    '{mpsm_pkg::REQ_PEND,  8'h00, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'h68, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'h65, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PEND,  8'h00, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'h73, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'h68, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'h65, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PEND,  8'h00, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'h68, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'h65, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PEND,  8'h00, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'hff, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PEND,  8'h00, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_TEXT,  8'h75, 1'b1, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_TEXT,  8'h73, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_TEXT,  8'h68, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_TEXT,  8'h65, 1'b0, 1,  1'b0, '0},
    '{2'd3,                8'hff, 1'b1, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_TEXT,  8'hff, 1'b1, 1,  1'b1,
      '{mpsm_pkg::ST_MATCH, 8'd4, 32'd0, 1'b1}},
    '{mpsm_pkg::REQ_TEXT,  8'h00, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'h78, 1'b0, 32, 1'b0, '0},
    '{mpsm_pkg::REQ_PCHAR, 8'h78, 1'b0, 1,  1'b1,
      '{mpsm_pkg::ST_TOO_LONG, 8'd0, 32'd0, 1'b1}},
    '{mpsm_pkg::REQ_PEND,  8'h00, 1'b0, 1,  1'b0, '0},
    '{mpsm_pkg::REQ_TEXT,  8'h78, 1'b1, 1,  1'b0, '0}
  };

  initial begin
    int plen;
    req_ch.valid = 1'b0;
    req_ch.req_type = mpsm_pkg::REQ_PCHAR;
    req_ch.symbol = 8'h00;
    req_ch.text_start = 1'b0;
    res_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      repeat (directed[i].reps)
        send(directed[i].req, directed[i].sym, directed[i].restart,
             directed[i].typed, directed[i].res);

    // random rounds: a few patterns, then a run of text
    repeat (4) begin
      repeat ($urandom_range(2, 5)) begin
        plen = $urandom_range(1, 4);
        repeat (plen) send(mpsm_pkg::REQ_PCHAR, pick_sym(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0) send(2'd3, 8'($urandom), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) != 0)
          send(mpsm_pkg::REQ_PEND, 8'($urandom), 1'($urandom_range(0, 1)));
      end
      repeat (30)
        send(mpsm_pkg::REQ_TEXT, pick_sym(), $urandom_range(0, 9) == 0);
    end

    // back-to-back text, no idling from here on
    idle_on = 1'b0;
    repeat (20) send(mpsm_pkg::REQ_TEXT, pick_sym(), $urandom_range(0, 9) == 0);
    req_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("multi_pattern_string_matcher regression: pass");
    end else begin
      $display("multi_pattern_string_matcher regression: fail");
    end
    $finish;
  end

endmodule
